FILE: rtl/core/tct_pkg.sv
// Package for the text console terminal core: codes, reset values and FSM states.
// No dependencies; used by text_console_terminal_core.

package tct_pkg;

    // Default screen store geometry
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_COLUMNS        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROWS           = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ATTRIBUTE      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_START     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_ENABLED   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SERIAL_ENABLED = 3'd5;

    // Register reset values
    localparam logic [7:0]  COLUMNS_RST   = 8'd80;
    localparam logic [6:0]  ROWS_RST      = 7'd25;
    localparam logic [7:0]  ATTRIBUTE_RST = 8'h07;
    localparam logic [15:0] PAGE_RST      = 16'h0000;

    // Screen cell after reset
    localparam logic [15:0] CELL_RST = 16'h0720;

    // Character codes
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_PRINT_MIN = 8'h20;

    localparam int TAB_STOP = 8;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_SET   = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_ERASE,
        ST_SCROLL,
        ST_FILL,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/core/tct_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module tct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/text_console_terminal_core.sv
// Text console terminal: screen store, cursor, scroll/clear sequencer, serial echo.
// Depends on tct_pkg and tct_ram.
//
//  channel  | dir | transfer                   | payload
//  ---------+-----+----------------------------+-----------------------------------------
//  s_axis   | in  | tvalid & tready            | tuser: kind; tdata: character,row,column
//  m_axis   | out | tvalid & tready            | tuser: serial_valid; tdata: byte,pos,cell
//  apb      | in  | psel & penable & pwrite    | six registers at byte address 4*index
//
// Steps: a printable byte is accepted, decoded, written to its cell and emitted as a result;
// a tab takes one cell write per space, a read cell a memory read and a wait. A scroll
// copies columns*(rows-1) cells up and blanks the bottom row, and a clear blanks
// columns*rows cells: the single memory write port moves one cell a cycle.
// After reset a clearing pass writes all MAX_COLUMNS*MAX_ROWS cells (8192 by default)
// with s_axis_tready low. The last result of an item sits in the output register
// while the next item is accepted; earlier results stall the sequencer.

module text_console_terminal_core #(
    parameter int MAX_COLUMNS = tct_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tct_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // input items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [23:0]                     s_axis_tdata,  // character[7:0], row[13:8],
                                                           // column[20:14], zero pad
    input  logic [1:0]                      s_axis_tuser,  // kind[1:0]

    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // serial_byte[7:0],
                                                           // cursor_position[23:8],
                                                           // cell_value[39:24]
    output logic [0:0]                      m_axis_tuser,  // serial_valid[0]
    output logic                            m_axis_tlast,

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tct_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tct_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tct_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int Depth   = MAX_COLUMNS * MAX_ROWS;
    localparam int AW      = $clog2(Depth);
    localparam int LW      = $clog2(Depth + 1);
    localparam int RW      = $clog2(MAX_ROWS);
    localparam int CCW     = $clog2(MAX_COLUMNS);
    localparam int ECW     = $clog2(MAX_COLUMNS + 1);
    localparam int CmpW    = ((ECW > 8) ? ECW : 8) + 1;
    localparam int TabBits = $clog2(tct_pkg::TAB_STOP);
    localparam int CntW    = $clog2(tct_pkg::TAB_STOP + 1);

    // configuration registers
    logic [7:0]  r_columns;
    logic [6:0]  r_rows;
    logic [7:0]  r_attr;
    logic [15:0] r_page;
    logic        r_text_en;
    logic        r_serial_en;

    // sequencer state
    tct_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_wa, n_wa;
    logic [RW-1:0]   r_crow, n_crow;
    logic [CCW-1:0]  r_ccol, n_ccol;
    logic [AW-1:0]   r_lin;
    logic [AW-1:0]   r_tlin;
    logic [LW-1:0]   r_total;
    logic [LW-1:0]   r_copy;
    tct_pkg::t_kind  r_kind, n_kind;
    logic [7:0]      r_putch, n_putch;
    logic [RW-1:0]   r_trow, n_trow;
    logic [CCW-1:0]  r_tcol, n_tcol;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [7:0]      r_echo [3];
    logic [7:0]      n_echo [3];
    logic [1:0]      r_necho, n_necho;
    logic [1:0]      r_k, n_k;
    logic [15:0]     r_cell, n_cell;

    // output register
    logic            r_ovalid, n_ovalid;
    logic            r_osv, n_osv;
    logic [7:0]      r_obyte, n_obyte;
    logic [15:0]     r_opos, n_opos;
    logic [15:0]     r_ocell, n_ocell;
    logic            r_olast, n_olast;

    // memory port
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [15:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [15:0]     mem_rdata;

    // combinational helpers
    logic [CmpW-1:0] cols_x, rows_x, ec, er;
    logic [LW-1:0]   lin_next, tlin_next, total_next, scroll_src;
    logic [15:0]     blank;
    logic            cfg_wr;
    logic [tct_pkg::REG_IDX_W-1:0] reg_idx;
    logic [CmpW-1:0] in_row_x, in_col_x;
    logic [1:0]      count;
    logic            has_echo;
    logic            last_res;
    logic            col_wrap, row_past;

    // ------------------------------------------------------------------
    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[tct_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns   <= tct_pkg::COLUMNS_RST;
            r_rows      <= tct_pkg::ROWS_RST;
            r_attr      <= tct_pkg::ATTRIBUTE_RST;
            r_page      <= tct_pkg::PAGE_RST;
            r_text_en   <= 1'b1;
            r_serial_en <= 1'b1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tct_pkg::REG_COLUMNS:        r_columns   <= pwdata[7:0];
                tct_pkg::REG_ROWS:           r_rows      <= pwdata[6:0];
                tct_pkg::REG_ATTRIBUTE:      r_attr      <= pwdata[7:0];
                tct_pkg::REG_PAGE_START:     r_page      <= pwdata[15:0];
                tct_pkg::REG_TEXT_ENABLED:   r_text_en   <= pwdata[0];
                tct_pkg::REG_SERIAL_ENABLED: r_serial_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            tct_pkg::REG_COLUMNS:        prdata = {24'd0, r_columns};
            tct_pkg::REG_ROWS:           prdata = {25'd0, r_rows};
            tct_pkg::REG_ATTRIBUTE:      prdata = {24'd0, r_attr};
            tct_pkg::REG_PAGE_START:     prdata = {16'd0, r_page};
            tct_pkg::REG_TEXT_ENABLED:   prdata = {31'd0, r_text_en};
            tct_pkg::REG_SERIAL_ENABLED: prdata = {31'd0, r_serial_en};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // effective geometry: zero acts as one, above the store maximum saturates
    assign cols_x = CmpW'(r_columns);
    assign rows_x = CmpW'(r_rows);
    assign ec = (cols_x == '0) ? CmpW'(1) :
                (cols_x > CmpW'(MAX_COLUMNS)) ? CmpW'(MAX_COLUMNS) : cols_x;
    assign er = (rows_x == '0) ? CmpW'(1) :
                (rows_x > CmpW'(MAX_ROWS)) ? CmpW'(MAX_ROWS) : rows_x;

    assign blank = {r_attr, tct_pkg::CH_SPACE};

    // linear cell addresses
    assign lin_next   = LW'(n_crow) * LW'(ec) + LW'(n_ccol);
    assign tlin_next  = LW'(r_trow) * LW'(ec) + LW'(r_tcol);
    assign total_next = LW'(er) * LW'(ec);
    assign scroll_src = r_idx + LW'(ec);

    assign in_row_x = CmpW'(s_axis_tdata[13:8]);
    assign in_col_x = CmpW'(s_axis_tdata[20:14]);

    // cursor advance tests
    assign col_wrap = (CmpW'(r_ccol) + CmpW'(1)) >= ec;
    assign row_past = (CmpW'(r_crow) + CmpW'(1)) >= er;

    // result bookkeeping
    assign count    = (r_necho == 2'd0) ? 2'd1 : r_necho;
    assign has_echo = r_k < r_necho;
    assign last_res = (r_k + 2'd1) == count;

    // ------------------------------------------------------------------
    // next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_wa      = r_wa;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        n_kind    = r_kind;
        n_putch   = r_putch;
        n_trow    = r_trow;
        n_tcol    = r_tcol;
        n_cnt     = r_cnt;
        n_echo    = r_echo;
        n_necho   = r_necho;
        n_k       = r_k;
        n_cell    = r_cell;
        n_ovalid  = r_ovalid & ~m_axis_tready;
        n_osv     = r_osv;
        n_obyte   = r_obyte;
        n_opos    = r_opos;
        n_ocell   = r_ocell;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = r_lin;
        mem_wdata = blank;
        mem_raddr = r_tlin;
        s_axis_tready = 1'b0;

        unique case (r_state)
            // clearing pass over the whole store after reset
            tct_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = tct_pkg::CELL_RST;
                if (r_idx == LW'(Depth - 1)) begin
                    n_idx   = '0;
                    n_state = tct_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end

            // take an item, clamp cursor and targets to the geometry
            tct_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_kind  = tct_pkg::t_kind'(s_axis_tuser);
                    n_putch = s_axis_tdata[7:0];
                    n_trow  = (in_row_x >= er) ? RW'(er - CmpW'(1)) : RW'(in_row_x);
                    n_tcol  = (in_col_x >= ec) ? CCW'(ec - CmpW'(1)) : CCW'(in_col_x);
                    if (CmpW'(r_crow) >= er) n_crow = RW'(er - CmpW'(1));
                    if (CmpW'(r_ccol) >= ec) n_ccol = CCW'(ec - CmpW'(1));
                    n_cell  = '0;
                    n_k     = '0;
                    n_necho = '0;
                    n_cnt   = '0;
                    n_state = tct_pkg::ST_DECODE;
                end
            end

            tct_pkg::ST_DECODE: begin
                n_state = tct_pkg::ST_EMIT;
                unique case (r_kind)
                    tct_pkg::KIND_PUT: begin
                        if (r_putch == tct_pkg::CH_BS) begin
                            n_echo[0] = tct_pkg::CH_BS;
                            n_echo[1] = tct_pkg::CH_SPACE;
                            n_echo[2] = tct_pkg::CH_BS;
                            n_necho   = 2'd3;
                            if (r_text_en) begin
                                if (r_ccol == '0 && r_crow == '0) begin
                                    // nothing to erase at the top left corner
                                    n_necho = 2'd0;
                                end else begin
                                    if (r_ccol == '0) begin
                                        n_crow = r_crow - RW'(1);
                                        n_ccol = CCW'(ec - CmpW'(1));
                                    end else begin
                                        n_ccol = r_ccol - CCW'(1);
                                    end
                                    n_state = tct_pkg::ST_ERASE;
                                end
                            end
                        end else begin
                            if (r_putch == tct_pkg::CH_LF) begin
                                n_echo[0] = tct_pkg::CH_CR;
                                n_echo[1] = tct_pkg::CH_LF;
                                n_necho   = 2'd2;
                            end else begin
                                n_echo[0] = r_putch;
                                n_necho   = 2'd1;
                            end
                            if (r_text_en) begin
                                if (r_putch == tct_pkg::CH_LF) begin
                                    n_ccol = '0;
                                    if (row_past) begin
                                        n_crow  = RW'(er - CmpW'(1));
                                        n_idx   = '0;
                                        n_pend  = 1'b0;
                                        n_state = tct_pkg::ST_SCROLL;
                                    end else begin
                                        n_crow = r_crow + RW'(1);
                                    end
                                end else if (r_putch == tct_pkg::CH_CR) begin
                                    n_ccol = '0;
                                end else if (r_putch == tct_pkg::CH_TAB) begin
                                    // spaces up to the next tab stop
                                    n_cnt   = CntW'(tct_pkg::TAB_STOP)
                                              - CntW'(r_ccol[TabBits-1:0]);
                                    n_putch = tct_pkg::CH_SPACE;
                                    n_state = tct_pkg::ST_PUT;
                                end else if (r_putch >= tct_pkg::CH_PRINT_MIN) begin
                                    n_cnt   = CntW'(1);
                                    n_state = tct_pkg::ST_PUT;
                                end
                            end
                        end
                    end
                    tct_pkg::KIND_CLEAR: begin
                        n_crow = '0;
                        n_ccol = '0;
                        if (r_text_en) begin
                            n_idx   = '0;
                            n_state = tct_pkg::ST_FILL;
                        end
                    end
                    tct_pkg::KIND_SET: begin
                        if (r_text_en) begin
                            n_crow = r_trow;
                            n_ccol = r_tcol;
                        end
                    end
                    tct_pkg::KIND_READ: begin
                        n_state = tct_pkg::ST_RD_ISSUE;
                    end
                    default: ;
                endcase
            end

            // store one character at the cursor and advance
            tct_pkg::ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_lin;
                mem_wdata = {r_attr, r_putch};
                n_cnt     = r_cnt - CntW'(1);
                n_state   = (r_cnt == CntW'(1)) ? tct_pkg::ST_EMIT : tct_pkg::ST_PUT;
                if (col_wrap) begin
                    n_ccol = '0;
                    if (row_past) begin
                        n_crow  = RW'(er - CmpW'(1));
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = tct_pkg::ST_SCROLL;
                    end else begin
                        n_crow = r_crow + RW'(1);
                    end
                end else begin
                    n_ccol = r_ccol + CCW'(1);
                end
            end

            // blank the cell left of the old cursor
            tct_pkg::ST_ERASE: begin
                mem_we    = 1'b1;
                mem_waddr = r_lin;
                mem_wdata = blank;
                n_state   = tct_pkg::ST_EMIT;
            end

            // move every cell up one row: read ahead, write each cell in the cycle after its read
            tct_pkg::ST_SCROLL: begin
                mem_we    = r_pend;
                mem_waddr = r_wa;
                mem_wdata = mem_rdata;
                if (r_idx < r_copy) begin
                    mem_raddr = scroll_src[AW-1:0];
                    n_pend    = 1'b1;
                    n_wa      = r_idx[AW-1:0];
                    n_idx     = r_idx + LW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = tct_pkg::ST_FILL;
                end
            end

            // blank cells from the index up to the end of the screen
            tct_pkg::ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = blank;
                if (r_idx == r_total - LW'(1)) begin
                    n_state = (r_cnt != '0) ? tct_pkg::ST_PUT : tct_pkg::ST_EMIT;
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end

            tct_pkg::ST_RD_ISSUE: begin
                mem_raddr = r_tlin;
                n_state   = tct_pkg::ST_RD_WAIT;
            end

            tct_pkg::ST_RD_WAIT: begin
                n_cell  = mem_rdata;
                n_state = tct_pkg::ST_EMIT;
            end

            // one result per echo byte (a single result when there is none) into the output register
            tct_pkg::ST_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_osv    = has_echo & r_serial_en;
                    n_obyte  = has_echo ? r_echo[r_k] : 8'd0;
                    n_opos   = r_page + 16'(r_lin);
                    n_ocell  = r_cell;
                    n_olast  = last_res;
                    n_k      = r_k + 2'd1;
                    if (last_res) begin
                        n_state = tct_pkg::ST_IDLE;
                    end
                end
            end

            default: n_state = tct_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tct_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_crow   <= '0;
            r_ccol   <= '0;
            r_lin    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_crow   <= n_crow;
            r_ccol   <= n_ccol;
            r_lin    <= lin_next[AW-1:0];
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wa    <= n_wa;
        r_tlin  <= tlin_next[AW-1:0];
        r_total <= total_next;
        r_copy  <= total_next - LW'(ec);
        r_kind  <= n_kind;
        r_putch <= n_putch;
        r_trow  <= n_trow;
        r_tcol  <= n_tcol;
        r_cnt   <= n_cnt;
        r_echo  <= n_echo;
        r_necho <= n_necho;
        r_k     <= n_k;
        r_cell  <= n_cell;
        r_osv   <= n_osv;
        r_obyte <= n_obyte;
        r_opos  <= n_opos;
        r_ocell <= n_ocell;
        r_olast <= n_olast;
    end

    // ------------------------------------------------------------------
    // screen store
    tct_ram #(
        .WIDTH(16),
        .DEPTH(Depth)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // result channel
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ocell, r_opos, r_obyte};
    assign m_axis_tuser  = r_osv;
    assign m_axis_tlast  = r_olast;

endmodule
